>>> src/swf_pkg.sv
// ----------------------------------------------------------------------------
// swf_pkg
// Shared types and constants for the staggered wavefunction step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swf_pkg;

    localparam int DATA_W    = 32;
    localparam int COEF_W    = 31;
    localparam int IDX_W     = 10;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KINETIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_IN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_OUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 3'd4;

    localparam logic [COEF_W-1:0] KINETIC_RST = 31'h2000_0000;
    localparam logic [IDX_W-1:0]  CENTER_RST  = 10'd512;
    localparam logic [IDX_W-1:0]  HALF_RST    = 10'd500;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] UMAX    = 32'hFFFF_FFFF;

    // MODE_RE: old + h, MODE_IM: old - h, MODE_MAG: a1*b1 + a2*b2 unsigned
    typedef enum logic [1:0] {
        MODE_RE,
        MODE_IM,
        MODE_MAG
    } upd_mode_t;

    typedef struct packed {
        logic      valid;
        upd_mode_t mode;
    } upd_ctl_t;

endpackage

>>> src/swf_mem.sv
// ----------------------------------------------------------------------------
// swf_mem
// Grid sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swf_mem
    import swf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/swf_update.sv
// ----------------------------------------------------------------------------
// swf_update
// Shared three-stage multiply-accumulate unit: two products, rounding to
// Q1.30, then a saturating update of the old sample or an unsigned clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swf_update
    import swf_pkg::*;
#(
    parameter int AW = 10
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  upd_ctl_t                 in_ctl,
    input  logic [AW-1:0]            in_addr,
    input  logic signed [DATA_W-1:0] op_a1,
    input  logic signed [DATA_W-1:0] op_b1,
    input  logic signed [DATA_W-1:0] op_a2,
    input  logic signed [DATA_W-1:0] op_b2,
    input  logic signed [DATA_W-1:0] in_old,
    output upd_ctl_t                 out_ctl,
    output logic [AW-1:0]            out_addr,
    output logic [DATA_W-1:0]        out_result,
    output logic                     busy
);

    localparam int PW = 2 * DATA_W;
    localparam int DW = PW + 2;
    localparam int HW = DW - 30;
    localparam int SW = HW + 1;
    localparam logic [DW-1:0] RND = DW'(1) << 29;

    upd_ctl_t                 ctl1_reg, ctl2_reg, ctl3_reg;
    logic [AW-1:0]            addr1_reg, addr2_reg, addr3_reg;
    logic [DATA_W-1:0]        old1_reg, old2_reg;
    logic signed [PW-1:0]     p1_reg, p2_reg;
    logic [HW-1:0]            h_reg;
    logic [DATA_W-1:0]        res_reg;

    logic [DW-1:0]            p1_ext, p2_ext, d_sum;
    logic [SW-1:0]            old_ext, h_ext, s_sum;
    logic [DATA_W-1:0]        res_next;

    always_comb
    begin
        p1_ext = {{2{p1_reg[PW-1]}}, p1_reg};
        p2_ext = {{2{p2_reg[PW-1]}}, p2_reg};
        if (ctl1_reg.mode == MODE_MAG)
        begin
            d_sum = p1_ext + p2_ext + RND;
        end
        else
        begin
            d_sum = p1_ext - p2_ext + RND;
        end
    end

    always_comb
    begin
        old_ext = {{(SW-DATA_W){old2_reg[DATA_W-1]}}, old2_reg};
        h_ext   = {h_reg[HW-1], h_reg};
        s_sum   = '0;
        res_next = '0;
        unique case (ctl2_reg.mode)
            MODE_RE,
            MODE_IM:
            begin
                s_sum = (ctl2_reg.mode == MODE_IM) ? (old_ext - h_ext) : (old_ext + h_ext);
                if (s_sum[SW-1:DATA_W-1] == '0 || s_sum[SW-1:DATA_W-1] == '1)
                begin
                    res_next = s_sum[DATA_W-1:0];
                end
                else
                begin
                    res_next = s_sum[SW-1] ? SAT_MIN : SAT_MAX;
                end
            end
            MODE_MAG:
            begin
                res_next = (h_reg[HW-1:DATA_W] != '0) ? UMAX : h_reg[DATA_W-1:0];
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        addr1_reg <= in_addr;
        old1_reg  <= in_old;
        p1_reg    <= op_a1 * op_b1;
        p2_reg    <= op_a2 * op_b2;
        addr2_reg <= addr1_reg;
        old2_reg  <= old1_reg;
        h_reg     <= d_sum[DW-1:30];
        addr3_reg <= addr2_reg;
        res_reg   <= res_next;
    end

    assign out_ctl    = ctl3_reg;
    assign out_addr   = addr3_reg;
    assign out_result = res_reg;
    assign busy       = ctl1_reg.valid | ctl2_reg.valid | ctl3_reg.valid;

endmodule

>>> src/staggered_wavefunction_step_unit.sv
// ----------------------------------------------------------------------------
// staggered_wavefunction_step_unit
// Holds a 1-D grid of complex Q1.30 samples and advances it with a staggered
// finite-difference time step. A write is stored in the cycle it is taken; a
// read waits while its previous result is still held at the output. A time
// step makes two sweeps over the grid, one point per cycle, set by the
// single read port of each store feeding the shared multiply unit, with a
// pipeline drain after each sweep. After reset the stores are cleared, one
// address per cycle, before the first request is taken; configuration writes
// are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module staggered_wavefunction_step_unit
    import swf_pkg::*;
#(
    parameter int GRID_POINTS = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [IDX_W-1:0]         index,
    input  logic signed [DATA_W-1:0] re_in,
    input  logic signed [DATA_W-1:0] im_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] re_out,
    output logic signed [DATA_W-1:0] im_out,
    output logic [DATA_W-1:0]        magnitude_sq
);

    localparam int AW = $clog2(GRID_POINTS);
    localparam int CW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
    localparam int PW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int LW = DATA_W + 2;
    localparam logic [AW-1:0] CNT_LAST = AW'(GRID_POINTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RDWAIT,
        ST_RDDATA,
        ST_RDRES
    } state_t;

    state_t                   state_reg;
    logic                     pass_im_reg;
    logic [AW-1:0]            cnt_reg;
    logic                     arr_valid_reg;
    logic [AW-1:0]            arr_j_reg;
    logic [DATA_W-1:0]        xa_reg, xb_reg;
    upd_ctl_t                 s0_ctl_reg;
    logic [AW-1:0]            s0_addr_reg;
    logic signed [DATA_W-1:0] s0_a1_reg, s0_b1_reg, s0_a2_reg, s0_b2_reg, s0_old_reg;
    logic [AW-1:0]            idx_reg;
    logic                     idx_ok_reg;
    logic [DATA_W-1:0]        rd_re_reg, rd_im_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        re_out_reg, im_out_reg, mag_reg;

    logic [COEF_W-1:0]        kinetic_coef_reg;
    logic [DATA_W-1:0]        pot_in_reg, pot_out_reg;
    logic [IDX_W-1:0]         well_center_reg, well_half_reg;

    logic                     in_fire;
    logic                     in_range;
    logic                     point_valid;
    logic [AW-1:0]            pt_i;
    logic [DATA_W-1:0]        x_rd, old_rd;
    logic [LW-1:0]            lap_w;
    logic [DATA_W-1:0]        lap;
    logic [PW-1:0]            diff, well_dist;
    logic                     in_well;
    logic [DATA_W-1:0]        rd_re_sel, rd_im_sel;

    logic                     re_we, im_we;
    logic [AW-1:0]            re_waddr, im_waddr, re_raddr, im_raddr;
    logic [DATA_W-1:0]        re_wdata, im_wdata, re_rdata, im_rdata;

    upd_ctl_t                 res_ctl;
    logic [AW-1:0]            res_addr;
    logic [DATA_W-1:0]        res_data;
    logic                     upd_busy;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_range = CW'(index) < CW'(GRID_POINTS);

    // stencil window: X[i-1] = xb, X[i] = xa, X[i+1] = read data
    assign point_valid = arr_valid_reg && (arr_j_reg >= AW'(2));
    assign pt_i        = arr_j_reg - AW'(1);
    assign x_rd        = pass_im_reg ? re_rdata : im_rdata;
    assign old_rd      = pass_im_reg ? im_rdata : re_rdata;

    always_comb
    begin
        lap_w = {{2{xb_reg[DATA_W-1]}}, xb_reg} + {{2{x_rd[DATA_W-1]}}, x_rd}
              - {xa_reg[DATA_W-1], xa_reg, 1'b0};
        if (lap_w[LW-1:DATA_W-1] == '0 || lap_w[LW-1:DATA_W-1] == '1)
        begin
            lap = lap_w[DATA_W-1:0];
        end
        else
        begin
            lap = lap_w[LW-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_comb
    begin
        diff      = PW'(pt_i) - PW'(well_center_reg);
        well_dist = diff[PW-1] ? (PW'(0) - diff) : diff;
        in_well   = well_dist < PW'(well_half_reg);
    end

    assign rd_re_sel = idx_ok_reg ? re_rdata : '0;
    assign rd_im_sel = idx_ok_reg ? im_rdata : '0;

    // store port selection
    always_comb
    begin
        re_we    = 1'b0;
        re_waddr = res_addr;
        re_wdata = res_data;
        im_we    = 1'b0;
        im_waddr = res_addr;
        im_wdata = res_data;
        priority if (state_reg == ST_CLEAR)
        begin
            re_we    = 1'b1;
            re_waddr = cnt_reg;
            re_wdata = '0;
            im_we    = 1'b1;
            im_waddr = cnt_reg;
            im_wdata = '0;
        end
        else if (in_fire && func == FUNC_WRITE)
        begin
            re_we    = in_range;
            re_waddr = AW'(index);
            re_wdata = re_in;
            im_we    = in_range;
            im_waddr = AW'(index);
            im_wdata = im_in;
        end
        else
        begin
            re_we = res_ctl.valid && res_ctl.mode == MODE_RE;
            im_we = res_ctl.valid && res_ctl.mode == MODE_IM;
        end
    end

    always_comb
    begin
        if (state_reg == ST_RDWAIT)
        begin
            re_raddr = idx_reg;
            im_raddr = idx_reg;
        end
        else if (pass_im_reg)
        begin
            re_raddr = cnt_reg;
            im_raddr = cnt_reg - AW'(1);
        end
        else
        begin
            re_raddr = cnt_reg - AW'(1);
            im_raddr = cnt_reg;
        end
    end

    swf_mem #(
        .DEPTH (GRID_POINTS),
        .AW    (AW)
    ) u_real_mem (
        .clk   (clk),
        .we    (re_we),
        .waddr (re_waddr),
        .wdata (re_wdata),
        .raddr (re_raddr),
        .rdata (re_rdata)
    );

    swf_mem #(
        .DEPTH (GRID_POINTS),
        .AW    (AW)
    ) u_imag_mem (
        .clk   (clk),
        .we    (im_we),
        .waddr (im_waddr),
        .wdata (im_wdata),
        .raddr (im_raddr),
        .rdata (im_rdata)
    );

    swf_update #(
        .AW (AW)
    ) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (s0_ctl_reg),
        .in_addr    (s0_addr_reg),
        .op_a1      (s0_a1_reg),
        .op_b1      (s0_b1_reg),
        .op_a2      (s0_a2_reg),
        .op_b2      (s0_b2_reg),
        .in_old     (s0_old_reg),
        .out_ctl    (res_ctl),
        .out_addr   (res_addr),
        .out_result (res_data),
        .busy       (upd_busy)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kinetic_coef_reg <= KINETIC_RST;
            pot_in_reg       <= '0;
            pot_out_reg      <= '0;
            well_center_reg  <= CENTER_RST;
            well_half_reg    <= HALF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KINETIC: kinetic_coef_reg <= cfg_data[COEF_W-1:0];
                CFG_POT_IN:  pot_in_reg       <= cfg_data;
                CFG_POT_OUT: pot_out_reg      <= cfg_data;
                CFG_CENTER:  well_center_reg  <= cfg_data[IDX_W-1:0];
                CFG_HALF:    well_half_reg    <= cfg_data[IDX_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pass_im_reg   <= 1'b0;
            cnt_reg       <= '0;
            arr_valid_reg <= 1'b0;
            arr_j_reg     <= '0;
            s0_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            arr_valid_reg <= (state_reg == ST_SWEEP);
            arr_j_reg     <= cnt_reg;

            if (point_valid)
            begin
                s0_ctl_reg <= '{valid: 1'b1, mode: (pass_im_reg ? MODE_IM : MODE_RE)};
            end
            else if (state_reg == ST_RDDATA)
            begin
                s0_ctl_reg <= '{valid: 1'b1, mode: MODE_MAG};
            end
            else
            begin
                s0_ctl_reg <= '0;
            end

            if (res_ctl.valid && res_ctl.mode == MODE_MAG)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (func == FUNC_STEP)
                        begin
                            pass_im_reg <= 1'b0;
                            cnt_reg     <= '0;
                            state_reg   <= ST_SWEEP;
                        end
                        else if (func == FUNC_READ)
                        begin
                            state_reg <= ST_RDWAIT;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!arr_valid_reg && !s0_ctl_reg.valid && !upd_busy)
                    begin
                        if (!pass_im_reg)
                        begin
                            pass_im_reg <= 1'b1;
                            state_reg   <= ST_SWEEP;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RDWAIT:
                begin
                    if (!out_valid_reg)
                    begin
                        state_reg <= ST_RDDATA;
                    end
                end
                ST_RDDATA:
                begin
                    state_reg <= ST_RDRES;
                end
                ST_RDRES:
                begin
                    if (res_ctl.valid)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (arr_valid_reg)
        begin
            xb_reg <= xa_reg;
            xa_reg <= x_rd;
        end

        if (in_fire)
        begin
            idx_reg    <= AW'(index);
            idx_ok_reg <= in_range;
        end

        if (state_reg == ST_RDDATA)
        begin
            rd_re_reg   <= rd_re_sel;
            rd_im_reg   <= rd_im_sel;
            s0_addr_reg <= idx_reg;
            s0_a1_reg   <= rd_re_sel;
            s0_b1_reg   <= rd_re_sel;
            s0_a2_reg   <= rd_im_sel;
            s0_b2_reg   <= rd_im_sel;
            s0_old_reg  <= '0;
        end
        else
        begin
            s0_addr_reg <= pt_i;
            s0_a1_reg   <= in_well ? pot_in_reg : pot_out_reg;
            s0_b1_reg   <= xa_reg;
            s0_a2_reg   <= {1'b0, kinetic_coef_reg};
            s0_b2_reg   <= lap;
            s0_old_reg  <= old_rd;
        end

        if (res_ctl.valid && res_ctl.mode == MODE_MAG)
        begin
            re_out_reg <= rd_re_reg;
            im_out_reg <= rd_im_reg;
            mag_reg    <= res_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign re_out       = re_out_reg;
    assign im_out       = im_out_reg;
    assign magnitude_sq = mag_reg;

    a_upd_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ctl.valid && res_ctl.mode != MODE_MAG)
            |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("sample update outside a time step");

    a_upd_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ctl.valid && res_ctl.mode != MODE_MAG)
            |-> (res_addr != '0 && res_addr != CNT_LAST))
        else $error("update hit a fixed end point");

    a_mag_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ctl.valid && res_ctl.mode == MODE_MAG)
            |-> (!out_valid_reg && state_reg == ST_RDRES))
        else $error("read result would overwrite a pending result");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RDRES))
        else $error("result raised without a read request");

endmodule
